// File: rtl/dalm_pkg.sv
// ----------------------------------------------------------------------------
// dalm_pkg
// Types and constants shared by the display/audio latency monitor modules.
// ----------------------------------------------------------------------------
package dalm_pkg;

  localparam int unsigned TimeW  = 48;
  localparam int unsigned CountW = 32;
  localparam int unsigned CmdW   = 3;
  localparam int unsigned ChanW  = 2;

  localparam logic [TimeW-1:0] ThresholdReset = TimeW'(500000);

  // Command codes
  localparam logic [CmdW-1:0] CmdMark      = 3'd0;
  localparam logic [CmdW-1:0] CmdFrame     = 3'd1;
  localparam logic [CmdW-1:0] CmdAudio     = 3'd2;
  localparam logic [CmdW-1:0] CmdAudioRst  = 3'd3;
  localparam logic [CmdW-1:0] CmdStatsRst  = 3'd4;

  typedef logic [TimeW-1:0]  time_t;
  typedef logic [CountW-1:0] count_t;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [ChanW-1:0] channel;
    time_t            timestamp;
  } dalm_in_t;

  typedef struct packed {
    logic   monitor_enabled;
    count_t frame_count;
    time_t  max_delay;
    time_t  max_update_gap;
    count_t update_count;
    count_t violation_count;
    time_t  pending_age;
    time_t  audio_max_gap;
    count_t audio_count;
  } dalm_out_t;

  // Per-beat control broadcast to every lane; mark, frame and progress bits already
  // qualified by the enable flag, and all command bits by the beat actually firing.
  typedef struct packed {
    logic             clear;
    logic             mark;
    logic             frame;
    logic             progress;
    logic             audio_clr;
    logic [ChanW-1:0] channel;
    time_t            ts;
  } lane_ctrl_t;

  typedef struct packed {
    time_t  max_delay;
    time_t  max_update_gap;
    count_t update_count;
    count_t violation_count;
    time_t  pending_age;
  } disp_stats_t;

  typedef struct packed {
    time_t  max_gap;
    count_t count;
  } audio_stats_t;

endpackage

// File: rtl/dalm_disp_lane.sv
// ----------------------------------------------------------------------------
// dalm_disp_lane
// State and update logic of one display channel: pending mark, worst delay,
// worst update gap, update and violation counters.
// ----------------------------------------------------------------------------
module dalm_disp_lane
  import dalm_pkg::*;
#(
  parameter int unsigned LANE_ID = 0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  lane_ctrl_t  ctrl_i,
  input  time_t       threshold_i,
  output disp_stats_t stats_o
);

  time_t  pend_q, pend_d;
  time_t  worst_q, worst_d;
  time_t  last_q, last_d;
  time_t  gap_max_q, gap_max_d;
  count_t upd_q, upd_d;
  count_t late_q, late_d;

  logic  hit;
  time_t delay;
  time_t gap;

  assign hit   = (32'(ctrl_i.channel) == LANE_ID);
  assign delay = ctrl_i.ts - pend_q;
  assign gap   = ctrl_i.ts - last_q;

  always_comb begin
    pend_d    = pend_q;
    worst_d   = worst_q;
    last_d    = last_q;
    gap_max_d = gap_max_q;
    upd_d     = upd_q;
    late_d    = late_q;
    if (ctrl_i.clear) begin
      pend_d    = '0;
      worst_d   = '0;
      last_d    = '0;
      gap_max_d = '0;
      upd_d     = '0;
      late_d    = '0;
    end else if (ctrl_i.mark && hit) begin
      // keep the earliest request
      if (pend_q == '0 || ctrl_i.ts < pend_q) begin
        pend_d = ctrl_i.ts;
      end
    end else if (ctrl_i.frame && pend_q != '0) begin
      // time going backwards skips the delay and violation checks
      if (ctrl_i.ts >= pend_q) begin
        if (delay > worst_q) begin
          worst_d = delay;
        end
        if (delay >= threshold_i) begin
          late_d = late_q + 1'b1;
        end
      end
      if (last_q != '0 && ctrl_i.ts >= last_q && gap > gap_max_q) begin
        gap_max_d = gap;
      end
      last_d = ctrl_i.ts;
      upd_d  = upd_q + 1'b1;
      pend_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= '0;
      worst_q   <= '0;
      last_q    <= '0;
      gap_max_q <= '0;
      upd_q     <= '0;
      late_q    <= '0;
    end else begin
      pend_q    <= pend_d;
      worst_q   <= worst_d;
      last_q    <= last_d;
      gap_max_q <= gap_max_d;
      upd_q     <= upd_d;
      late_q    <= late_d;
    end
  end

  // Report the state as it stands after this beat's effect.
  always_comb begin
    stats_o.max_delay       = worst_d;
    stats_o.max_update_gap  = gap_max_d;
    stats_o.update_count    = upd_d;
    stats_o.violation_count = late_d;
    stats_o.pending_age     = (pend_d != '0 && ctrl_i.ts >= pend_d) ?
                              (ctrl_i.ts - pend_d) : '0;
  end

endmodule

// File: rtl/dalm_audio_lane.sv
// ----------------------------------------------------------------------------
// dalm_audio_lane
// State and update logic of one audio direction: last progress time, worst
// gap and call counter.
// ----------------------------------------------------------------------------
module dalm_audio_lane
  import dalm_pkg::*;
#(
  parameter int unsigned LANE_ID = 0
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  lane_ctrl_t   ctrl_i,
  output audio_stats_t stats_o
);

  time_t  last_q, last_d;
  time_t  gap_max_q, gap_max_d;
  count_t calls_q, calls_d;

  logic  hit;
  time_t gap;

  assign hit = (32'(ctrl_i.channel) == LANE_ID);
  assign gap = ctrl_i.ts - last_q;

  always_comb begin
    last_d    = last_q;
    gap_max_d = gap_max_q;
    calls_d   = calls_q;
    if (ctrl_i.clear) begin
      last_d    = '0;
      gap_max_d = '0;
      calls_d   = '0;
    end else if (ctrl_i.audio_clr) begin
      last_d = '0;
    end else if (ctrl_i.progress && hit) begin
      if (last_q != '0 && ctrl_i.ts >= last_q && gap > gap_max_q) begin
        gap_max_d = gap;
      end
      last_d  = ctrl_i.ts;
      calls_d = calls_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q    <= '0;
      gap_max_q <= '0;
      calls_q   <= '0;
    end else begin
      last_q    <= last_d;
      gap_max_q <= gap_max_d;
      calls_q   <= calls_d;
    end
  end

  assign stats_o.max_gap = gap_max_d;
  assign stats_o.count   = calls_d;

endmodule

// File: rtl/display_audio_latency_monitor.sv
// A beat accepted at a clock edge sits in the input register, and its result
// is loaded into the result register when the beat fires.
// Throughput: one item per cycle; a stalled result blocks input only once both
// the input and the result register hold a beat.
// Reset: all statistics and counters clear, monitoring disabled, threshold
// returns to 500000 us.
// ----------------------------------------------------------------------------
// display_audio_latency_monitor
// Tracks mark-to-frame delays and update gaps of display channels and the
// progress gaps of audio directions; returns the stats of each beat's channel.
// ----------------------------------------------------------------------------
module display_audio_latency_monitor
  import dalm_pkg::*;
#(
  parameter int unsigned DISPLAY_CHANNELS = 3,
  parameter int unsigned AUDIO_CHANNELS   = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  dalm_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output dalm_out_t out_data_o,
  input  logic      cfg_we_i,
  input  time_t     cfg_wdata_i
);

  logic      in_valid_q;
  dalm_in_t  in_q;
  logic      out_valid_q;
  dalm_out_t out_q, out_d;
  time_t     threshold_q;
  logic      enabled_q, enabled_d;
  count_t    frames_q, frames_d;

  logic       advance;
  logic       fire;
  logic       in_accept;
  lane_ctrl_t ctrl;

  disp_stats_t  disp_stats  [DISPLAY_CHANNELS];
  audio_stats_t audio_stats [AUDIO_CHANNELS];

  // Advance whenever the result register is free or being drained.
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    ctrl.clear     = fire && (in_q.cmd == CmdStatsRst);
    ctrl.mark      = fire && enabled_q && (in_q.cmd == CmdMark);
    ctrl.frame     = fire && enabled_q && (in_q.cmd == CmdFrame);
    ctrl.progress  = fire && enabled_q && (in_q.cmd == CmdAudio);
    ctrl.audio_clr = fire && (in_q.cmd == CmdAudioRst);
    ctrl.channel   = in_q.channel;
    ctrl.ts        = in_q.timestamp;
  end

  always_comb begin
    enabled_d = enabled_q;
    frames_d  = frames_q;
    if (ctrl.clear) begin
      enabled_d = 1'b1;
      frames_d  = '0;
    end else if (ctrl.frame) begin
      frames_d = frames_q + 1'b1;
    end
  end

  for (genvar g = 0; g < DISPLAY_CHANNELS; g++) begin : g_disp
    dalm_disp_lane #(
      .LANE_ID (g)
    ) u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .threshold_i (threshold_q),
      .stats_o     (disp_stats[g])
    );
  end

  for (genvar g = 0; g < AUDIO_CHANNELS; g++) begin : g_audio
    dalm_audio_lane #(
      .LANE_ID (g)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .stats_o (audio_stats[g])
    );
  end

  // Select the beat's channel; channel fields of out-of-range channels read zero.
  always_comb begin
    out_d                 = '0;
    out_d.monitor_enabled = enabled_d;
    out_d.frame_count     = frames_d;
    for (int i = 0; i < DISPLAY_CHANNELS; i++) begin
      if (32'(in_q.channel) == i) begin
        out_d.max_delay       = disp_stats[i].max_delay;
        out_d.max_update_gap  = disp_stats[i].max_update_gap;
        out_d.update_count    = disp_stats[i].update_count;
        out_d.violation_count = disp_stats[i].violation_count;
        out_d.pending_age     = disp_stats[i].pending_age;
      end
    end
    for (int i = 0; i < AUDIO_CHANNELS; i++) begin
      if (32'(in_q.channel) == i) begin
        out_d.audio_max_gap = audio_stats[i].max_gap;
        out_d.audio_count   = audio_stats[i].count;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      enabled_q   <= 1'b0;
      frames_q    <= '0;
      threshold_q <= ThresholdReset;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      enabled_q <= enabled_d;
      frames_q  <= frames_d;
      if (cfg_we_i) begin
        threshold_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
